// ===== design/ntp_seconds_to_clock_alarm_assert.svh =====
// Assertion macros for the NTP clock alarm block
`ifndef NTP_SECONDS_TO_CLOCK_ALARM_ASSERT_SVH
`define NTP_SECONDS_TO_CLOCK_ALARM_ASSERT_SVH

`ifndef SYNTH
`define NTPA_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
`define NTPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NTPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NTPA_ASSERT(lbl, expr)
`define NTPA_ASSERT_IMP(lbl, ante, cons)
`define NTPA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/ntpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ntpa_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_RESYNC = 2'd1,
    CMD_STOP   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_WAKE_HOUR    = 3'd0,
    REG_ALARM_MINUTE = 3'd1,
    REG_ALARM_PM     = 3'd2,
    REG_ZONE_OFFSET  = 3'd3,
    REG_HOLD_UPDATE  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic        is_stop;
    logic [31:0] word;
  } queue_item_t;

  typedef struct packed {
    logic [3:0]  wake_hour;
    logic [5:0]  alarm_minute;
    logic        alarm_pm;
    logic [16:0] zone_offset;
    logic        hold_update;
  } cfg_t;

  localparam logic [31:0] NTP_UNIX_DELTA = 32'd2208988800;
  localparam logic [3:0]  RST_WAKE_HOUR  = 4'd12;
  localparam logic [5:0]  RST_ALARM_MIN  = 6'd0;
  localparam logic        RST_ALARM_PM   = 1'b1;
  localparam logic [16:0] RST_ZONE       = 17'd18000;

  // 86400 = 128 * 675; floor(2^34 / 675)
  localparam logic [24:0] DAY_DIV        = 25'd675;
  localparam logic [24:0] DAY_RECIP      = 25'd25451658;
  localparam int unsigned DAY_SHIFT      = 34;
  // minutes = (day >> 2) / 15; ceil(2^19 / 15)
  localparam logic [15:0] MIN_RECIP      = 16'd34953;
  localparam int unsigned MIN_SHIFT      = 19;
  // hours = (minutes >> 2) / 15; ceil(2^13 / 15)
  localparam logic [9:0]  HOUR_RECIP     = 10'd547;
  localparam int unsigned HOUR_SHIFT     = 13;

  localparam logic [4:0]  HALF_DAY_HOURS = 5'd12;
  localparam logic [10:0] MINS_PER_HOUR  = 11'd60;

endpackage
`default_nettype wire

// ===== design/ntpa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ntpa_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           command_i,
  input  wire logic [7:0]           rx_byte_i,
  output logic                      push_valid_o,
  input  wire logic                 push_ready_i,
  output ntpa_pkg::queue_item_t     push_item_o
);

  logic [1:0]  byte_cnt_q, byte_cnt_d;
  logic [31:0] acc_q, acc_d;
  logic        accept;
  logic [4:0]  shift;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign shift      = {2'(2'd3 - byte_cnt_q), 3'b000};

  always_comb begin
    byte_cnt_d           = byte_cnt_q;
    acc_d                = acc_q;
    push_valid_o         = 1'b0;
    push_item_o.is_stop  = 1'b0;
    push_item_o.word     = {acc_q[31:8], rx_byte_i};
    case (ntpa_pkg::cmd_e'(command_i))
      ntpa_pkg::CMD_BYTE: begin
        push_valid_o = in_valid_i && (byte_cnt_q == 2'd3);
        if (accept) begin
          byte_cnt_d = 2'(byte_cnt_q + 2'd1);
          if (byte_cnt_q == 2'd0) begin
            acc_d = {rx_byte_i, 24'd0};
          end else begin
            acc_d = acc_q | (32'(rx_byte_i) << shift);
          end
        end
      end
      ntpa_pkg::CMD_RESYNC: begin
        if (accept) begin
          byte_cnt_d = 2'd0;
        end
      end
      ntpa_pkg::CMD_STOP: begin
        push_valid_o        = in_valid_i;
        push_item_o.is_stop = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= 2'd0;
      acc_q      <= 32'd0;
    end else begin
      byte_cnt_q <= byte_cnt_d;
      acc_q      <= acc_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/ntpa_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ntpa_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_valid_i,
  output logic                       push_ready_o,
  input  wire ntpa_pkg::queue_item_t push_item_i,
  output logic                       pop_valid_o,
  input  wire logic                  pop_ready_i,
  output ntpa_pkg::queue_item_t      pop_item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  ntpa_pkg::queue_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
      end
      if (push && !pop) begin
        count_q <= CntW'(count_q + 1'b1);
      end else if (pop && !push) begin
        count_q <= CntW'(count_q - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/ntpa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ntpa_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ntpa_pkg::cfg_t        cfg_i,
  input  wire logic                  pop_valid_i,
  output logic                       pop_ready_o,
  input  wire ntpa_pkg::queue_item_t pop_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [31:0]                unix_seconds_o,
  output logic [3:0]                 clock_hour_o,
  output logic [5:0]                 clock_minute_o,
  output logic                       clock_pm_o,
  output logic                       clock_updated_o,
  output logic                       alarm_start_o,
  output logic                       alarm_active_o
);

  localparam int unsigned DAY_SHIFT_HI = ntpa_pkg::DAY_SHIFT + 15;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, out_valid_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy_out;
  logic s1_q, s2_q, s3_q, s4_q, s5_q, s6_q, s7_q;
  logic [31:0] unix1_q, unix2_q, unix3_q, unix4_q, unix5_q, unix6_q, unix7_q;
  logic [31:0] local2_q;
  logic [49:0] prod3_q;
  logic [24:0] hi3_q;
  logic [6:0]  low3_q, low4_q;
  logic [10:0] rem4_q;
  logic [16:0] day5_q;
  logic [10:0] mins6_q, mins7_q;
  logic [4:0]  h7_q;
  logic        playing_q;

  logic [15:0] quo4;
  logic [24:0] qm4, rem4_full;
  logic [9:0]  rem5;
  logic [30:0] prod6;
  logic [18:0] prod7;
  logic [8:0]  mins7_in;
  logic [10:0] min_full;
  logic [5:0]  minute;
  logic [3:0]  hour;
  logic        pm, match, fire, adv_out;

  logic [31:0] unix_q;
  logic [3:0]  hour_q;
  logic [5:0]  minute_q;
  logic        pm_q, updated_q, start_q, active_q;

  assign rdy_out     = !out_valid_q || out_ready_i;
  assign rdy7        = !v7_q || rdy_out;
  assign rdy6        = !v6_q || rdy7;
  assign rdy5        = !v5_q || rdy6;
  assign rdy4        = !v4_q || rdy5;
  assign rdy3        = !v3_q || rdy4;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign pop_ready_o = rdy1;
  assign adv_out     = v7_q && rdy_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      out_valid_q <= 1'b0;
      playing_q   <= 1'b0;
    end else begin
      if (rdy1)    v1_q <= pop_valid_i;
      if (rdy2)    v2_q <= v1_q;
      if (rdy3)    v3_q <= v2_q;
      if (rdy4)    v4_q <= v3_q;
      if (rdy5)    v5_q <= v4_q;
      if (rdy6)    v6_q <= v5_q;
      if (rdy7)    v7_q <= v6_q;
      if (rdy_out) out_valid_q <= v7_q && !s7_q;
      if (adv_out) begin
        if (s7_q) begin
          playing_q <= 1'b0;
        end else if (fire) begin
          playing_q <= 1'b1;
        end
      end
    end
  end

  assign mins7_in = mins6_q[10:2];

  // Second of day (reduce by 675 above the low seven bits), minute and hour products
  always_comb begin
    quo4      = prod3_q[DAY_SHIFT_HI-:16];
    qm4       = 25'(quo4) * ntpa_pkg::DAY_DIV;
    rem4_full = hi3_q - qm4;
    rem5      = (rem4_q >= 11'(ntpa_pkg::DAY_DIV)) ?
                10'(rem4_q - 11'(ntpa_pkg::DAY_DIV)) : rem4_q[9:0];
    prod6     = 31'(day5_q[16:2]) * 31'(ntpa_pkg::MIN_RECIP);
    prod7     = 19'(mins7_in) * 19'(ntpa_pkg::HOUR_RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_q    <= pop_item_i.is_stop;
      unix1_q <= pop_item_i.word - ntpa_pkg::NTP_UNIX_DELTA;
    end
    if (rdy2) begin
      s2_q     <= s1_q;
      unix2_q  <= unix1_q;
      local2_q <= unix1_q - 32'(cfg_i.zone_offset);
    end
    if (rdy3) begin
      s3_q    <= s2_q;
      unix3_q <= unix2_q;
      hi3_q   <= local2_q[31:7];
      low3_q  <= local2_q[6:0];
      prod3_q <= 50'(local2_q[31:7]) * 50'(ntpa_pkg::DAY_RECIP);
    end
    if (rdy4) begin
      s4_q    <= s3_q;
      unix4_q <= unix3_q;
      low4_q  <= low3_q;
      rem4_q  <= rem4_full[10:0];
    end
    if (rdy5) begin
      s5_q    <= s4_q;
      unix5_q <= unix4_q;
      day5_q  <= {rem5, low4_q};
    end
    if (rdy6) begin
      s6_q    <= s5_q;
      unix6_q <= unix5_q;
      mins6_q <= prod6[ntpa_pkg::MIN_SHIFT+:11];
    end
    if (rdy7) begin
      s7_q    <= s6_q;
      unix7_q <= unix6_q;
      mins7_q <= mins6_q;
      h7_q    <= prod7[ntpa_pkg::HOUR_SHIFT+:5];
    end
  end

  always_comb begin
    min_full = mins7_q - 11'(h7_q) * ntpa_pkg::MINS_PER_HOUR;
    minute   = min_full[5:0];
    if (h7_q == 5'd0) begin
      hour = 4'(ntpa_pkg::HALF_DAY_HOURS);
    end else if (h7_q > ntpa_pkg::HALF_DAY_HOURS) begin
      hour = 4'(h7_q - ntpa_pkg::HALF_DAY_HOURS);
    end else begin
      hour = h7_q[3:0];
    end
    pm    = (h7_q >= ntpa_pkg::HALF_DAY_HOURS);
    match = (hour == cfg_i.wake_hour) && (minute == cfg_i.alarm_minute) &&
            (pm == cfg_i.alarm_pm);
    fire  = !cfg_i.hold_update && match && !playing_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && !s7_q) begin
      unix_q    <= unix7_q;
      hour_q    <= cfg_i.hold_update ? 4'd0 : hour;
      minute_q  <= cfg_i.hold_update ? 6'd0 : minute;
      pm_q      <= cfg_i.hold_update ? 1'b0 : pm;
      updated_q <= !cfg_i.hold_update;
      start_q   <= fire;
      active_q  <= playing_q || fire;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign unix_seconds_o  = unix_q;
  assign clock_hour_o    = hour_q;
  assign clock_minute_o  = minute_q;
  assign clock_pm_o      = pm_q;
  assign clock_updated_o = updated_q;
  assign alarm_start_o   = start_q;
  assign alarm_active_o  = active_q;

endmodule
`default_nettype wire

// ===== design/ntp_seconds_to_clock_alarm.sv =====
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o | command_i, rx_byte_i
// out     | output    | out_valid_o/out_ready_i | unix_seconds_o .. alarm_active_o
// cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One item per cycle sustained unless the output is held back; a word result
// passes the queue, the back pipeline with its divide-by-constant stages and
// the output register. Reset clears byte count, accumulator, alarm flag and
// all valids; registers return to their reset values. Input stalls only when
// the queue is full, which happens only while the output is held back.
`timescale 1ns / 1ps
`default_nettype none
`include "ntp_seconds_to_clock_alarm_assert.svh"
module ntp_seconds_to_clock_alarm #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      unix_seconds_o,
  output logic [3:0]       clock_hour_o,
  output logic [5:0]       clock_minute_o,
  output logic             clock_pm_o,
  output logic             clock_updated_o,
  output logic             alarm_start_o,
  output logic             alarm_active_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_data_i
);

  ntpa_pkg::cfg_t        cfg_q;
  ntpa_pkg::queue_item_t push_item, pop_item;
  logic                  push_valid, push_ready, pop_valid, pop_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wake_hour    <= ntpa_pkg::RST_WAKE_HOUR;
      cfg_q.alarm_minute <= ntpa_pkg::RST_ALARM_MIN;
      cfg_q.alarm_pm     <= ntpa_pkg::RST_ALARM_PM;
      cfg_q.zone_offset  <= ntpa_pkg::RST_ZONE;
      cfg_q.hold_update  <= 1'b0;
    end else if (cfg_we_i) begin
      case (ntpa_pkg::reg_idx_e'(cfg_idx_i))
        ntpa_pkg::REG_WAKE_HOUR:    cfg_q.wake_hour    <= cfg_data_i[3:0];
        ntpa_pkg::REG_ALARM_MINUTE: cfg_q.alarm_minute <= cfg_data_i[5:0];
        ntpa_pkg::REG_ALARM_PM:     cfg_q.alarm_pm     <= cfg_data_i[0];
        ntpa_pkg::REG_ZONE_OFFSET:  cfg_q.zone_offset  <= cfg_data_i;
        ntpa_pkg::REG_HOLD_UPDATE:  cfg_q.hold_update  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ntpa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .rx_byte_i    (rx_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  ntpa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  ntpa_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_item_i      (pop_item),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .unix_seconds_o  (unix_seconds_o),
    .clock_hour_o    (clock_hour_o),
    .clock_minute_o  (clock_minute_o),
    .clock_pm_o      (clock_pm_o),
    .clock_updated_o (clock_updated_o),
    .alarm_start_o   (alarm_start_o),
    .alarm_active_o  (alarm_active_o)
  );

  `NTPA_ASSERT_IMP(a_start_active, out_valid_o && alarm_start_o,
                   alarm_active_o && clock_updated_o)
  `NTPA_ASSERT_IMP(a_hold_blank, out_valid_o && !clock_updated_o,
                   !alarm_start_o && clock_hour_o == 4'd0 && clock_minute_o == 6'd0)
  `NTPA_ASSERT_IMP(a_time_range, out_valid_o && clock_updated_o,
                   clock_hour_o >= 4'd1 && clock_hour_o <= 4'd12 && clock_minute_o <= 6'd59)
  `NTPA_ASSERT_IMP(a_stop_item, in_valid_i && in_ready_o && command_i == ntpa_pkg::CMD_STOP,
                   push_valid && push_item.is_stop)
  `NTPA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(unix_seconds_o))

endmodule
`default_nettype wire
